@@ design/lpht_pkg.sv @@
// Shared types, codes and constants for the linear probing hash table.
package lpht_pkg;

	localparam int KEY_W          = 16;
	localparam int VALUE_W        = 32;
	localparam int PROBES_W       = 4;
	localparam int MOD_STEPS      = 2;
	localparam int STEP_W         = $clog2(MOD_STEPS);
	localparam int QUEUE_DEPTH    = 2;
	localparam int TABLE_SIZE_DEF = 16;

	localparam logic [PROBES_W-1:0] PROBES_MAX = '1;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_FULL      = 2'd1,
		ST_FOUND     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_SEARCH = 1'b1
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic               valid;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} slot_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MOD,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_PROBE
	} back_state_t;

endpackage

@@ design/lpht_front.sv @@
// Front end: accepts requests and works out the home slot by reciprocal multiplication.
module lpht_front #(
	parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF,
	localparam int HOME_W = $clog2(TABLE_SIZE)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          op,
	input  logic [lpht_pkg::KEY_W-1:0]    key,
	input  logic [lpht_pkg::VALUE_W-1:0]  value,
	input  logic                          hold,
	input  logic                          q_full,
	output logic                          q_push,
	output lpht_pkg::req_t                q_req,
	output logic [HOME_W-1:0]             q_home
);

	localparam int RECIP_W = 32;
	localparam int PROD_W  = lpht_pkg::KEY_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'((64'd1 << RECIP_W) / 64'(TABLE_SIZE));
	localparam logic [lpht_pkg::KEY_W-1:0] N_KEY = lpht_pkg::KEY_W'(TABLE_SIZE);

	lpht_pkg::front_state_t             state_q, state_d;
	logic [lpht_pkg::STEP_W-1:0]        step_q;
	lpht_pkg::req_t                     req_q;
	logic [PROD_W-1:0]                  prod;
	logic [lpht_pkg::KEY_W-1:0]         quot_q, diff, rem_full;
	logic [HOME_W-1:0]                  rem_q;
	logic                               accept;

	assign in_stall = (state_q != lpht_pkg::F_IDLE) || hold;
	assign accept   = in_valid && !in_stall;
	assign q_req    = req_q;
	assign q_home   = rem_q;

	// estimate the quotient, then correct the remainder by one subtraction
	always_comb begin
		prod     = PROD_W'(req_q.key) * PROD_W'(RECIP);
		diff     = req_q.key - quot_q * N_KEY;
		rem_full = (diff >= N_KEY) ? diff - N_KEY : diff;
	end

	always_comb begin
		state_d = state_q;
		q_push  = 1'b0;
		unique case (state_q)
			lpht_pkg::F_IDLE: begin
				if (accept) begin
					state_d = lpht_pkg::F_MOD;
				end
			end
			lpht_pkg::F_MOD: begin
				if (step_q == lpht_pkg::STEP_W'(lpht_pkg::MOD_STEPS - 1)) begin
					state_d = lpht_pkg::F_PUSH;
				end
			end
			lpht_pkg::F_PUSH: begin
				if (!q_full) begin
					q_push  = 1'b1;
					state_d = lpht_pkg::F_IDLE;
				end
			end
			default: begin
				state_d = lpht_pkg::F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpht_pkg::F_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				step_q <= '0;
			end else if (state_q == lpht_pkg::F_MOD) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= '{op: lpht_pkg::op_t'(op), key: key, value: value};
		end else if (state_q == lpht_pkg::F_MOD) begin
			quot_q <= prod[PROD_W-1:RECIP_W];
			rem_q  <= rem_full[HOME_W-1:0];
		end
	end

endmodule

@@ design/lpht_queue.sv @@
// Short request queue between the front end and the probe engine.
module lpht_queue #(
	parameter int DATA_W = 1,
	parameter int DEPTH  = lpht_pkg::QUEUE_DEPTH,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic [DATA_W-1:0] pop_data,
	output logic              not_empty
);

	logic [DATA_W-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_push, do_pop;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = entry_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= push_data;
		end
	end

endmodule

@@ design/lpht_back.sv @@
// Probe engine: slot memory, clearing pass, linear probe walk and result register.
module lpht_back #(
	parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF,
	localparam int HOME_W = $clog2(TABLE_SIZE)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	input  lpht_pkg::req_t                 q_req,
	input  logic [HOME_W-1:0]              q_home,
	output logic                           q_pop,
	output logic                           clearing,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     status,
	output logic [lpht_pkg::PROBES_W-1:0]  probes,
	output logic [lpht_pkg::VALUE_W-1:0]   found_value
);

	localparam logic [HOME_W-1:0] LAST_SLOT = HOME_W'(TABLE_SIZE - 1);

	lpht_pkg::slot_t                    mem [TABLE_SIZE];
	lpht_pkg::slot_t                    rd_q, wd;
	lpht_pkg::back_state_t              state_q, state_d;
	lpht_pkg::req_t                     req_q;
	lpht_pkg::status_t                  fin_status;
	logic [HOME_W-1:0]                  home_q, pos_q, clr_q, nxt, ra, wa;
	logic [lpht_pkg::PROBES_W-1:0]      passed_q, fin_probes, probes_q;
	logic [lpht_pkg::VALUE_W-1:0]       fin_value, found_q;
	logic [1:0]                         status_q;
	logic                               out_valid_q, out_free, we, fin, advance;
	logic                               hit, wrapped;

	assign nxt         = (pos_q == LAST_SLOT) ? '0 : pos_q + 1'b1;
	assign wrapped     = (nxt == home_q);
	assign hit         = rd_q.valid && (rd_q.key == req_q.key);
	assign out_free    = !out_valid_q || !out_stall;
	assign clearing    = (state_q == lpht_pkg::B_CLEAR);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign probes      = probes_q;
	assign found_value = found_q;

	always_comb begin
		state_d    = state_q;
		ra         = pos_q;
		wa         = pos_q;
		we         = 1'b0;
		wd         = '{valid: 1'b1, key: req_q.key, value: req_q.value};
		q_pop      = 1'b0;
		fin        = 1'b0;
		advance    = 1'b0;
		fin_status = lpht_pkg::ST_NOT_FOUND;
		fin_probes = '0;
		fin_value  = '0;
		unique case (state_q)
			lpht_pkg::B_CLEAR: begin
				ra = clr_q;
				wa = clr_q;
				we = 1'b1;
				wd = '0;
				if (clr_q == LAST_SLOT) begin
					state_d = lpht_pkg::B_IDLE;
				end
			end
			lpht_pkg::B_IDLE: begin
				ra = q_home;
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = lpht_pkg::B_PROBE;
				end
			end
			lpht_pkg::B_PROBE: begin
				if (req_q.op == lpht_pkg::OP_INSERT) begin
					priority if (!rd_q.valid) begin
						fin_status = lpht_pkg::ST_INSERTED;
						fin_probes = passed_q;
						fin        = out_free;
						we         = out_free;
					end else if (wrapped) begin
						fin_status = lpht_pkg::ST_FULL;
						fin        = out_free;
					end else begin
						advance = 1'b1;
					end
				end else begin
					priority if (hit) begin
						fin_status = lpht_pkg::ST_FOUND;
						fin_value  = rd_q.value;
						fin        = out_free;
					end else if (!rd_q.valid || wrapped) begin
						fin_status = lpht_pkg::ST_NOT_FOUND;
						fin        = out_free;
					end else begin
						advance = 1'b1;
					end
				end
				if (advance) begin
					ra = nxt;
				end
				if (fin) begin
					state_d = lpht_pkg::B_IDLE;
				end
			end
			default: begin
				state_d = lpht_pkg::B_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lpht_pkg::B_CLEAR;
			clr_q       <= '0;
			passed_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == lpht_pkg::B_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (q_pop) begin
				passed_q <= '0;
			end else if (advance && (passed_q != lpht_pkg::PROBES_MAX)) begin
				passed_q <= passed_q + 1'b1;
			end
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
		if (q_pop) begin
			req_q  <= q_req;
			home_q <= q_home;
			pos_q  <= q_home;
		end else if (advance) begin
			pos_q <= nxt;
		end
		if (fin) begin
			status_q <= fin_status;
			probes_q <= fin_probes;
			found_q  <= fin_value;
		end
	end

endmodule

@@ design/linear_probe_hash_table_unit.sv @@
// Linear probing hash table: top level joining front end, queue and probe engine.
//
// Input channel (in_valid / in_stall) takes one request: op 0 inserts key and
// value, op 1 searches for key. Output channel (out_valid / out_stall) returns
// one result per request: status, probes (occupied slots passed on a successful
// insert) and found_value (stored word on a successful search).
// The front end handles each request in turn: acceptance, the F_MOD state
// that finds the home slot (key modulo TABLE_SIZE by reciprocal multiplication
// and one correction) and the F_PUSH state that hands it to a two-entry queue,
// waiting while the queue is full. The probe engine takes a request from the
// queue and makes one memory read for each slot visited.
// The front end can accept a new request while the probe engine still walks
// the slots for an earlier one.
// After reset the engine clears the slot memory, one slot a cycle;
// in_stall stays high until that pass is done.
// A stalled result holds its register; the engine then waits with a finished
// request while the front end and queue keep taking new ones until full.
module linear_probe_hash_table_unit #(
	parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           op,
	input  logic [lpht_pkg::KEY_W-1:0]     key,
	input  logic [lpht_pkg::VALUE_W-1:0]   value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     status,
	output logic [lpht_pkg::PROBES_W-1:0]  probes,
	output logic [lpht_pkg::VALUE_W-1:0]   found_value
);

	localparam int HOME_W = $clog2(TABLE_SIZE);
	localparam int REQ_W  = $bits(lpht_pkg::req_t);
	localparam int DATA_W = REQ_W + HOME_W;

	lpht_pkg::req_t       f_req, b_req;
	logic [HOME_W-1:0]    f_home, b_home;
	logic [DATA_W-1:0]    q_out;
	logic                 q_push, q_full, q_pop, q_not_empty, clearing;

	assign b_req  = lpht_pkg::req_t'(q_out[REQ_W-1:0]);
	assign b_home = q_out[DATA_W-1:REQ_W];

	lpht_front #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.key      (key),
		.value    (value),
		.hold     (clearing),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_req    (f_req),
		.q_home   (f_home)
	);

	lpht_queue #(
		.DATA_W (DATA_W),
		.DEPTH  (lpht_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({f_home, f_req}),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.not_empty (q_not_empty)
	);

	lpht_back #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_not_empty),
		.q_req       (b_req),
		.q_home      (b_home),
		.q_pop       (q_pop),
		.clearing    (clearing),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.probes      (probes),
		.found_value (found_value)
	);

endmodule

@@ design/lpht_checker.sv @@
// Port-level checks for the hash table, bound to the top level.
module lpht_props (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [1:0]                     status,
	input logic [lpht_pkg::PROBES_W-1:0]  probes,
	input logic [lpht_pkg::VALUE_W-1:0]   found_value
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=>
			$stable(status) && $stable(probes) && $stable(found_value))
		else $error("stalled result changed");

	a_probes_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != lpht_pkg::ST_INSERTED) |-> probes == '0)
		else $error("probe count on a result that is not an insert");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != lpht_pkg::ST_FOUND) |-> found_value == '0)
		else $error("value on a result that is not a hit");

	a_reset_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> in_stall && !out_valid)
		else $error("request taken or result shown during clearing pass");

endmodule

bind linear_probe_hash_table_unit lpht_props u_lpht_props (.*);
